/* design/fdec_pkg.sv */
`timescale 1ns / 1ps

package fdec_pkg;

	localparam int SAMPLE_W    = 24;
	localparam int COEF_W      = 24;
	localparam int TAP_COUNT   = 511;
	localparam int DECIMATION  = 16;
	localparam int TAP_W       = $clog2(TAP_COUNT);
	localparam int DEC_BITS    = $clog2(DECIMATION);
	localparam int PROD_W      = SAMPLE_W + COEF_W;
	localparam int ACC_W       = PROD_W + TAP_W;
	localparam int FRAC_W      = COEF_W - 1;
	localparam int RND_W       = ACC_W - FRAC_W;
	localparam int COUNT_W     = 32;
	localparam int NUMBER_W    = 20;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_FIRST_EMIT   = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LIMIT = CFG_INDEX_W'(1);

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_COEF   = 1'b1;

	localparam logic [COUNT_W-1:0]  FIRST_EMIT_RESET = COUNT_W'(510);
	localparam logic [NUMBER_W-1:0] LIMIT_RESET      = {NUMBER_W{1'b1}};

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic valid;
		logic last;
	} issue_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       sat;
	} result_t;

endpackage

/* design/fdec_ram.sv */
`timescale 1ns / 1ps

module fdec_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 511
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/fdec_mac.sv */
`timescale 1ns / 1ps

module fdec_mac import fdec_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  issue_t                     issue,
	input  logic signed [SAMPLE_W-1:0] smp,
	input  logic signed [COEF_W-1:0]   coef,
	input  logic                       take,
	output logic                       res_valid,
	output result_t                    res
);

	localparam logic signed [RND_W-1:0] SAT_MAX =
		{{(RND_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [RND_W-1:0] SAT_MIN = ~SAT_MAX;
	localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) <<< (FRAC_W - 1);

	logic                      vld_s1, last_s1;
	logic                      vld_s2, last_s2;
	logic                      done_s3;
	logic                      vld_s4;
	logic                      res_valid_q;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [RND_W-1:0]   rnd_s4;
	logic signed [ACC_W-1:0]   biased;
	logic signed [PROD_W-1:0]  mul;
	result_t                   res_q;

	assign mul    = PROD_W'(smp) * PROD_W'(coef);
	assign biased = acc_q + RND_BIAS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			last_s1     <= 1'b0;
			vld_s2      <= 1'b0;
			last_s2     <= 1'b0;
			done_s3     <= 1'b0;
			vld_s4      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			vld_s1  <= issue.valid;
			last_s1 <= issue.valid & issue.last;
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
			done_s3 <= vld_s2 & last_s2;
			vld_s4  <= done_s3;
			if (vld_s4) begin
				res_valid_q <= 1'b1;
			end else if (take) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= mul;
		if (start) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (done_s3) begin
			rnd_s4 <= biased[ACC_W-1:FRAC_W];
		end
		if (vld_s4) begin
			if (rnd_s4 > SAT_MAX) begin
				res_q.sample <= SAT_MAX[SAMPLE_W-1:0];
				res_q.sat    <= 1'b1;
			end else if (rnd_s4 < SAT_MIN) begin
				res_q.sample <= SAT_MIN[SAMPLE_W-1:0];
				res_q.sat    <= 1'b1;
			end else begin
				res_q.sample <= rnd_s4[SAMPLE_W-1:0];
				res_q.sat    <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* design/fir_decimator_by_sixteen.sv */
// Decimating FIR filter with 511 taps and a factor of 16 on Q1.23 samples. After reset the
// block clears the delay line memory and holds in_stall high during that time; configuration
// writes are taken throughout. A coefficient load or a sample that makes no output word is
// taken without a stall. After a sample that makes an output word, in_stall stays high while
// the single multiply-accumulate unit reads one tap a cycle from the delay line and coefficient
// memories, its pipeline rounds and saturates the sum, and the result waits for the output
// register to be free. The block makes one output word per 16 samples. A finished word
// waits in the output register while the next words are accepted.
`timescale 1ns / 1ps

module fir_decimator_by_sixteen import fdec_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       command,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic [TAP_W-1:0]           coef_index,
	input  logic signed [COEF_W-1:0]   coef_value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] sample_out,
	output logic [NUMBER_W-1:0]        output_number,
	output logic                       saturated,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(TAP_COUNT - 1);

	state_t                     state_q, state_d;
	logic [TAP_W-1:0]           clr_q, wp_q, pos_q, tap_q;
	logic [COUNT_W-1:0]         sample_count_q, first_q, diff;
	logic [NUMBER_W-1:0]        out_count_q, limit_q, number_q;
	logic                       out_valid_q, sat_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;

	logic                       accept, emit, take, res_valid, out_free;
	logic                       dl_we, cf_we;
	logic [TAP_W-1:0]           dl_waddr;
	logic [SAMPLE_W-1:0]        dl_wdata, dl_rdata;
	logic [COEF_W-1:0]          cf_rdata;
	issue_t                     issue;
	result_t                    res;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid & ~in_stall;
	assign diff     = sample_count_q - first_q;
	assign emit     = accept && (command == CMD_SAMPLE) && (sample_count_q >= first_q)
	                  && (diff[DEC_BITS-1:0] == '0) && (out_count_q < limit_q);
	assign out_free = ~out_valid_q | ~out_stall;
	assign cfg_ready = 1'b1;

	always_comb begin
		state_d     = state_q;
		issue.valid = 1'b0;
		issue.last  = 1'b0;
		take        = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_TAP) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (emit) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				issue.valid = 1'b1;
				issue.last  = (tap_q == LAST_TAP);
				if (tap_q == LAST_TAP) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (res_valid && out_free) begin
					take    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			dl_we    = 1'b1;
			dl_waddr = clr_q;
			dl_wdata = '0;
		end else begin
			dl_we    = accept && (command == CMD_SAMPLE);
			dl_waddr = wp_q;
			dl_wdata = sample_in;
		end
	end

	assign cf_we = accept && (command == CMD_COEF) && (32'(coef_index) < TAP_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			wp_q           <= '0;
			sample_count_q <= '0;
			out_count_q    <= '0;
			first_q        <= FIRST_EMIT_RESET;
			limit_q        <= LIMIT_RESET;
			out_valid_q    <= 1'b0;
			pos_q          <= '0;
			tap_q          <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + TAP_W'(1);
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_FIRST_EMIT:   first_q <= cfg_data;
					REG_OUTPUT_LIMIT: limit_q <= cfg_data[NUMBER_W-1:0];
					default: ;
				endcase
			end
			if (accept && (command == CMD_SAMPLE)) begin
				wp_q           <= (wp_q == LAST_TAP) ? '0 : wp_q + TAP_W'(1);
				sample_count_q <= sample_count_q + COUNT_W'(1);
			end
			if (emit) begin
				out_count_q <= out_count_q + NUMBER_W'(1);
				pos_q       <= (wp_q == LAST_TAP) ? '0 : wp_q + TAP_W'(1);
				tap_q       <= '0;
			end else if (state_q == ST_RUN) begin
				pos_q <= (pos_q == LAST_TAP) ? '0 : pos_q + TAP_W'(1);
				tap_q <= tap_q + TAP_W'(1);
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (~out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			number_q <= out_count_q;
		end
		if (take) begin
			sample_out_q  <= res.sample;
			sat_q         <= res.sat;
			output_number <= number_q;
		end
	end

	fdec_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(TAP_COUNT)
	) u_delay_ram (
		.clk  (clk),
		.we   (dl_we),
		.waddr(dl_waddr),
		.wdata(dl_wdata),
		.raddr(pos_q),
		.rdata(dl_rdata)
	);

	fdec_ram #(
		.WIDTH(COEF_W),
		.DEPTH(TAP_COUNT)
	) u_coef_ram (
		.clk  (clk),
		.we   (cf_we),
		.waddr(coef_index),
		.wdata(coef_value),
		.raddr(tap_q),
		.rdata(cf_rdata)
	);

	fdec_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (emit),
		.issue    (issue),
		.smp      (signed'(dl_rdata)),
		.coef     (signed'(cf_rdata)),
		.take     (take),
		.res_valid(res_valid),
		.res      (res)
	);

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign saturated  = sat_q;

endmodule

/* sim/fir_decimator_by_sixteen_tb.sv */
`timescale 1ns / 1ps

module fir_decimator_by_sixteen_tb;
	import fdec_pkg::*;

	localparam logic signed [SAMPLE_W-1:0] SMAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SMIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [SAMPLE_W-1:0] HALF = SAMPLE_W'(1) << (SAMPLE_W - 2);
	localparam logic signed [COEF_W-1:0]   CMAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0]   CMIN = {1'b1, {(COEF_W-1){1'b0}}};
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LOW  = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HIGH = '1;
	localparam longint OUT_TOP    = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
	localparam longint OUT_BOTTOM = -(longint'(1) <<< (SAMPLE_W - 1));
	localparam int DRAIN_CYCLES = 600;
	localparam int LONG_HOLD    = 4000;
	localparam int RANDOM_PHASES = 4;
	localparam int PHASE_WORDS   = 140;

	typedef struct {
		logic signed [SAMPLE_W-1:0] value;
		logic [NUMBER_W-1:0]        number;
		logic                       clip;
	} out_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic command;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic [TAP_W-1:0] coef_index;
	logic signed [COEF_W-1:0] coef_value;
	logic out_valid;
	logic out_stall;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic [NUMBER_W-1:0] output_number;
	logic saturated;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic signed [SAMPLE_W-1:0] hist [TAP_COUNT];
	logic signed [COEF_W-1:0]   taps [TAP_COUNT];
	int unsigned hist_wr;
	logic [COUNT_W-1:0]  samples_seen;
	logic [NUMBER_W-1:0] outputs_made;
	logic [COUNT_W-1:0]  emit_start;
	logic [NUMBER_W-1:0] emit_limit;
	out_word_t due_outputs [$];

	bit gaps_on = 1'b1;
	int hold_cycles = 0;
	int fails = 0;
	int words_in = 0;
	int samples_in = 0;
	int coef_loads = 0;
	int words_checked = 0;
	int words_clipped = 0;

	fir_decimator_by_sixteen DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.sample_in(sample_in),
		.coef_index(coef_index),
		.coef_value(coef_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_out(sample_out),
		.output_number(output_number),
		.saturated(saturated),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 19))
			0: return SMAX;
			1: return SMIN;
			2: return '0;
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	function automatic logic signed [COEF_W-1:0] small_coef();
		return COEF_W'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic logic signed [COEF_W-1:0] rand_coef();
		if ($urandom_range(0, 3) == 0)
			return COEF_W'($urandom());
		return small_coef();
	endfunction

	function automatic out_word_t fir_window_sum();
		longint acc;
		int unsigned p;
		int t;
		out_word_t w;
		acc = 0;
		p = hist_wr;
		for (t = 0; t < TAP_COUNT; t++) begin
			acc += longint'(hist[p]) * longint'(taps[t]);
			p = (p + 1 == TAP_COUNT) ? 0 : p + 1;
		end
		acc = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
		if (acc > OUT_TOP) begin
			w.value = SMAX;
			w.clip = 1'b1;
		end else if (acc < OUT_BOTTOM) begin
			w.value = SMIN;
			w.clip = 1'b1;
		end else begin
			w.value = acc[SAMPLE_W-1:0];
			w.clip = 1'b0;
		end
		w.number = outputs_made;
		return w;
	endfunction

	task automatic decimator_step(input logic cmd, input logic signed [SAMPLE_W-1:0] smp,
			input logic [TAP_W-1:0] idx, input logic signed [COEF_W-1:0] cval);
		logic [COUNT_W-1:0] pos;
		logic [COUNT_W-1:0] lag;
		out_word_t w;
		if (cmd == CMD_COEF) begin
			coef_loads++;
			if (idx < TAP_COUNT)
				taps[idx] = cval;
		end else begin
			samples_in++;
			hist[hist_wr] = smp;
			hist_wr = (hist_wr + 1 == TAP_COUNT) ? 0 : hist_wr + 1;
			pos = samples_seen;
			samples_seen = samples_seen + 1'b1;
			lag = pos - emit_start;
			if (pos >= emit_start && lag[DEC_BITS-1:0] == '0 && outputs_made < emit_limit) begin
				w = fir_window_sum();
				due_outputs.insert(due_outputs.size(), w);
				outputs_made = outputs_made + 1'b1;
			end
		end
	endtask

	task automatic send_word(input logic cmd, input logic signed [SAMPLE_W-1:0] smp,
			input logic [TAP_W-1:0] idx, input logic signed [COEF_W-1:0] cval);
		int gap;
		command <= cmd;
		sample_in <= smp;
		coef_index <= idx;
		coef_value <= cval;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		words_in++;
		decimator_step(cmd, smp, idx, cval);
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
		send_word(CMD_SAMPLE, smp, TAP_W'($urandom()), COEF_W'($urandom()));
	endtask

	task automatic send_coef(input logic [TAP_W-1:0] idx, input logic signed [COEF_W-1:0] cval);
		send_word(CMD_COEF, SAMPLE_W'($urandom()), idx, cval);
	endtask

	task automatic send_random_words(input int count);
		int n;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 88)
				send_sample(rand_sample());
			else
				send_coef(TAP_W'($urandom_range(0, 2 ** TAP_W - 1)), rand_coef());
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (due_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		case (idx)
			REG_FIRST_EMIT: emit_start = data;
			REG_OUTPUT_LIMIT: emit_limit = data[NUMBER_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic test_coef_load();
		int i;
		for (i = 0; i < TAP_COUNT; i++)
			send_coef(TAP_W'(i), small_coef());
		send_coef('1, CMAX);
		wait_drained();
	endtask

	task automatic test_directed_corners();
		logic signed [SAMPLE_W-1:0] corner_vals [14];
		int i;
		corner_vals = '{SMAX, '0, -24'sd1, 24'sd1, HALF, -HALF, 24'sh2AAAAA, -24'sh2AAAAA,
			24'sh555555, 24'sh00FFFF, -24'sh00FFFF, SMIN + 24'sd1, SMAX - 24'sd1, 24'sh7F0000};
		write_reg(REG_FIRST_EMIT, '0);
		send_coef(TAP_W'(TAP_COUNT - 1), CMIN);
		send_coef(TAP_W'(TAP_COUNT - 2), CMAX);
		send_sample(SMIN);
		for (i = 0; i < 14; i++)
			send_sample(corner_vals[i]);
		send_sample(SMIN);
		send_sample(SMAX);
		send_coef(TAP_W'(TAP_COUNT - 1), small_coef());
		send_coef(TAP_W'(TAP_COUNT - 2), small_coef());
		wait_drained();
	endtask

	task automatic test_output_limit();
		int i;
		write_reg(REG_OUTPUT_LIMIT, CFG_DATA_W'(outputs_made) + 2);
		for (i = 0; i < 48; i++)
			send_sample(rand_sample());
		wait_drained();
		write_reg(REG_OUTPUT_LIMIT, '0);
		for (i = 0; i < 20; i++)
			send_sample(rand_sample());
		wait_drained();
		write_reg(REG_OUTPUT_LIMIT, '1);
		write_reg(REG_UNUSED_LOW, CFG_DATA_W'($urandom()));
		write_reg(REG_UNUSED_HIGH, CFG_DATA_W'($urandom()));
		for (i = 0; i < 32; i++)
			send_sample(rand_sample());
		wait_drained();
	endtask

	task automatic test_first_emit();
		int i;
		write_reg(REG_FIRST_EMIT, '1);
		for (i = 0; i < 32; i++)
			send_sample(rand_sample());
		wait_drained();
		write_reg(REG_FIRST_EMIT, samples_seen + 7);
		for (i = 0; i < 40; i++)
			send_sample(rand_sample());
		wait_drained();
	endtask

	task automatic test_output_backpressure();
		int i;
		gaps_on = 1'b0;
		hold_cycles = LONG_HOLD;
		for (i = 0; i < 80; i++)
			send_sample(rand_sample());
		gaps_on = 1'b1;
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int phase;
		logic [COUNT_W-1:0] start;
		logic [CFG_DATA_W-1:0] lim;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 3))
				0: start = samples_seen + $urandom_range(0, 40);
				1: start = samples_seen - $urandom_range(0, samples_seen);
				2: start = '0;
				default: start = samples_seen + $urandom_range(0, 15);
			endcase
			if ($urandom_range(0, 3) == 0)
				lim = CFG_DATA_W'(outputs_made) + $urandom_range(1, 5);
			else
				lim = {12'($urandom()), {NUMBER_W{1'b1}}};
			write_reg(REG_FIRST_EMIT, start);
			write_reg(REG_OUTPUT_LIMIT, lim);
			gaps_on = (phase != 1);
			send_random_words(PHASE_WORDS);
			gaps_on = 1'b1;
			wait_drained();
		end
	endtask

	initial begin
		int n;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles != 0) begin
				n = hold_cycles;
				hold_cycles = 0;
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				n = pick_gap();
				if (n != 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_outputs
		out_word_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (due_outputs.size() == 0) begin
				$error("output word %0d arrived with nothing expected", output_number);
				fails++;
			end else begin
				want = due_outputs.pop_front();
				words_checked++;
				if (want.clip)
					words_clipped++;
				if (sample_out !== want.value) begin
					$error("sample_out: expected %0d, got %0d", want.value, sample_out);
					fails++;
				end
				if (output_number !== want.number) begin
					$error("output_number: expected %0d, got %0d", want.number, output_number);
					fails++;
				end
				if (saturated !== want.clip) begin
					$error("saturated: expected %0b, got %0b", want.clip, saturated);
					fails++;
				end
			end
		end
	end

	initial begin
		int i;
		for (i = 0; i < TAP_COUNT; i++) begin
			hist[i] = '0;
			taps[i] = '0;
		end
		hist_wr = 0;
		samples_seen = '0;
		outputs_made = '0;
		emit_start = FIRST_EMIT_RESET;
		emit_limit = LIMIT_RESET;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_SAMPLE;
		sample_in <= '0;
		coef_index <= '0;
		coef_value <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_coef_load();
		test_directed_corners();
		test_output_limit();
		test_first_emit();
		test_output_backpressure();
		test_random_traffic();
		$display("Sent %0d words (%0d samples, %0d coefficient loads); %0d outputs checked.",
			words_in, samples_in, coef_loads, words_checked);
		$display("%0d outputs clipped; limits, first-output offsets and a long hold covered.",
			words_clipped);
		if (fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

/* sim.f */
design/fdec_pkg.sv
design/fdec_ram.sv
design/fdec_mac.sv
design/fir_decimator_by_sixteen.sv
sim/fir_decimator_by_sixteen_tb.sv
